// File: hw/rtl/small_matrix_inverse_macros.svh
// Assertion macros shared by the matrix inverse RTL.
// Depends on nothing; included by modules that check their own pipelines.
`ifndef SMALL_MATRIX_INVERSE_MACROS_SVH
`define SMALL_MATRIX_INVERSE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SMI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define SMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: hw/rtl/smi_pkg.sv
// Shared types and constants of the matrix inverse.
// Depends on nothing.
package smi_pkg;
	localparam int EntryWidth = 16;
	localparam int FracBits   = 8;
	localparam int ProdWidth  = 2 * EntryWidth;
	localparam int AdjWidth   = 2 * EntryWidth + 1;
	localparam int DetWidth   = 3 * EntryWidth + 2;
	localparam int ScaleBits  = FracBits + 16;
	localparam int NumWidth   = AdjWidth + ScaleBits + 1;
	localparam int QuoWidth   = NumWidth;
	localparam int ResWidth   = 32;

	typedef logic signed [EntryWidth-1:0] entry_t;
	typedef logic signed [AdjWidth-1:0] adj_t;
	typedef logic signed [DetWidth-1:0] det_t;
	typedef logic [ResWidth-1:0] res_t;
endpackage

// File: hw/rtl/smi_div_stage.sv
// One restoring-division step for all nine quotients: one quotient bit each.
// Depends on smi_pkg.
module smi_div_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vld_in,
	input  logic                        sing_in,
	input  logic [8:0]                  neg_in,
	input  logic [smi_pkg::DetWidth-1:0] den_in,
	input  logic [smi_pkg::NumWidth-1:0] num_in [9],
	input  logic [smi_pkg::DetWidth:0]   rem_in [9],
	input  logic [smi_pkg::QuoWidth-1:0] quo_in [9],
	output logic                        vld_out,
	output logic                        sing_out,
	output logic [8:0]                  neg_out,
	output logic [smi_pkg::DetWidth-1:0] den_out,
	output logic [smi_pkg::NumWidth-1:0] num_out [9],
	output logic [smi_pkg::DetWidth:0]   rem_out [9],
	output logic [smi_pkg::QuoWidth-1:0] quo_out [9]
);
	logic [smi_pkg::DetWidth+1:0] trial [9];
	logic [smi_pkg::DetWidth+1:0] diff [9];

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			trial[k] = {rem_in[k], num_in[k][smi_pkg::NumWidth-1]};
			diff[k]  = trial[k] - {2'b00, den_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		sing_out <= sing_in;
		neg_out  <= neg_in;
		den_out  <= den_in;
		for (int k = 0; k < 9; k++) begin
			num_out[k] <= {num_in[k][smi_pkg::NumWidth-2:0], 1'b0};
			if (!diff[k][smi_pkg::DetWidth+1]) begin
				rem_out[k] <= diff[k][smi_pkg::DetWidth:0];
				quo_out[k] <= {quo_in[k][smi_pkg::QuoWidth-2:0], 1'b1};
			end else begin
				rem_out[k] <= trial[k][smi_pkg::DetWidth:0];
				quo_out[k] <= {quo_in[k][smi_pkg::QuoWidth-2:0], 1'b0};
			end
		end
	end
endmodule

// File: hw/rtl/smi_adj.sv
// Determinant and adjugate front end: products, cofactors, determinant.
// Depends on smi_pkg.
module smi_adj (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld_in,
	input  logic                 size3_in,
	input  smi_pkg::entry_t      a [9],
	output logic                 vld_out,
	output smi_pkg::adj_t        adj_out [9],
	output smi_pkg::det_t        det_out
);
	localparam int PW = smi_pkg::ProdWidth;
	localparam int DW = smi_pkg::DetWidth;
	localparam int AW = smi_pkg::AdjWidth;

	// Stage 1: registered entries.
	smi_pkg::entry_t e_s1 [9];
	logic size3_s1, vld_s1;
	// Stage 2: 18 products.
	logic signed [PW-1:0] p_s2 [18];
	smi_pkg::entry_t e_s2 [9];
	logic size3_s2, vld_s2;
	// Stage 3: cofactors.
	smi_pkg::adj_t c_s3 [9];
	smi_pkg::entry_t e_s3 [3];
	logic size3_s3, vld_s3;
	// Stage 4: determinant terms.
	logic signed [DW-1:0] t_s4 [3];
	smi_pkg::adj_t c_s4 [9];
	logic size3_s4, vld_s4;

	// The 2x2 path is carried separately since it needs the raw entries.
	smi_pkg::entry_t q_s3 [4];
	smi_pkg::entry_t q_s4 [4];
	// 2x2 determinant equals the cofactor of entry 8, held one more stage.
	smi_pkg::adj_t det2_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Each cofactor k is the difference of products 2k and 2k+1.
	always_ff @(posedge clk) begin
		e_s1     <= a;
		size3_s1 <= size3_in;
		p_s2[0]  <= PW'(e_s1[4] * e_s1[8]);
		p_s2[1]  <= PW'(e_s1[5] * e_s1[7]);
		p_s2[2]  <= PW'(e_s1[2] * e_s1[7]);
		p_s2[3]  <= PW'(e_s1[1] * e_s1[8]);
		p_s2[4]  <= PW'(e_s1[1] * e_s1[5]);
		p_s2[5]  <= PW'(e_s1[2] * e_s1[4]);
		p_s2[6]  <= PW'(e_s1[5] * e_s1[6]);
		p_s2[7]  <= PW'(e_s1[3] * e_s1[8]);
		p_s2[8]  <= PW'(e_s1[0] * e_s1[8]);
		p_s2[9]  <= PW'(e_s1[2] * e_s1[6]);
		p_s2[10] <= PW'(e_s1[2] * e_s1[3]);
		p_s2[11] <= PW'(e_s1[0] * e_s1[5]);
		p_s2[12] <= PW'(e_s1[3] * e_s1[7]);
		p_s2[13] <= PW'(e_s1[4] * e_s1[6]);
		p_s2[14] <= PW'(e_s1[1] * e_s1[6]);
		p_s2[15] <= PW'(e_s1[0] * e_s1[7]);
		p_s2[16] <= PW'(e_s1[0] * e_s1[4]);
		p_s2[17] <= PW'(e_s1[1] * e_s1[3]);
		e_s2     <= e_s1;
		size3_s2 <= size3_s1;
		for (int k = 0; k < 9; k++) begin
			c_s3[k] <= AW'(p_s2[2*k]) - AW'(p_s2[2*k+1]);
		end
		e_s3[0]  <= e_s2[0];
		e_s3[1]  <= e_s2[1];
		e_s3[2]  <= e_s2[2];
		size3_s3 <= size3_s2;
		t_s4[0]  <= DW'(e_s3[0] * c_s3[0]);
		t_s4[1]  <= DW'(e_s3[1] * c_s3[3]);
		t_s4[2]  <= DW'(e_s3[2] * c_s3[6]);
		size3_s4 <= size3_s3;
		c_s4     <= c_s3;
	end

	always_ff @(posedge clk) begin
		q_s3[0] <= e_s2[0];
		q_s3[1] <= e_s2[1];
		q_s3[2] <= e_s2[3];
		q_s3[3] <= e_s2[4];
		q_s4    <= q_s3;
		det2_s4 <= c_s3[8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (size3_s4) begin
			adj_out <= c_s4;
			det_out <= t_s4[0] + t_s4[1] + t_s4[2];
		end else begin
			// 2x2: adjugate is a swap and negation of the four used entries.
			adj_out[0] <= AW'(q_s4[3]);
			adj_out[1] <= -AW'(q_s4[1]);
			adj_out[2] <= '0;
			adj_out[3] <= -AW'(q_s4[2]);
			adj_out[4] <= AW'(q_s4[0]);
			adj_out[5] <= '0;
			adj_out[6] <= '0;
			adj_out[7] <= '0;
			adj_out[8] <= '0;
			det_out    <= DW'(det2_s4);
		end
	end

	`include "small_matrix_inverse_macros.svh"
	`SMI_ASSERT_NEXT(a_vld_chain, clk, arst_n, vld_s4, vld_out)
	`SMI_ASSERT_NEXT(a_vld_head, clk, arst_n, vld_in, vld_s1)
	`SMI_ASSERT_IMPL(a_det_vld, clk, arst_n, vld_s2, vld_s1 == $past(vld_in))
endmodule

// File: hw/rtl/small_matrix_inverse.sv
// Adjugate matrix inverse of a 2x2 or 3x3 Q8.8 matrix, Q16.16 results.
// Depends on smi_pkg, smi_adj and smi_div_stage.
// One matrix is taken per clock cycle (busy is always low) and its result
// appears as a one-cycle done beat after the products and determinant, a
// set-up stage, 59 divider steps (58 quotient bits plus the rounding bit),
// and the rounding and output registers.
// The receiver cannot stall the block, so every done beat must be taken.
module small_matrix_inverse (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        size_is_3,
	input  smi_pkg::entry_t a00, a01, a02, a10, a11, a12, a20, a21, a22,
	output logic        done,
	output logic        singular,
	output logic signed [smi_pkg::ResWidth-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22
);
	localparam int NW = smi_pkg::NumWidth;
	localparam int DW = smi_pkg::DetWidth;
	localparam int QW = smi_pkg::QuoWidth;
	localparam int NSTG = NW + 1;

	smi_pkg::entry_t a [9];
	smi_pkg::adj_t adj [9];
	smi_pkg::det_t det;
	logic adj_vld;

	assign busy = 1'b0;
	assign a = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

	smi_adj u_adj (
		.clk(clk), .arst_n(arst_n), .vld_in(start), .size3_in(size_is_3), .a(a),
		.vld_out(adj_vld), .adj_out(adj), .det_out(det)
	);

	// Set-up stage: signs and magnitudes, numerator pre-scaled.
	logic vld_v [NSTG+1];
	logic sing_v [NSTG+1];
	logic [8:0] neg_v [NSTG+1];
	logic [DW-1:0] den_v [NSTG+1];
	logic [NW-1:0] num_v [NSTG+1][9];
	logic [DW:0] rem_v [NSTG+1][9];
	logic [QW-1:0] quo_v [NSTG+1][9];

	logic [DW-1:0] dmag;
	assign dmag = det[DW-1] ? DW'(-det) : DW'(det);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_v[0] <= 1'b0;
		end else begin
			vld_v[0] <= adj_vld;
		end
	end

	always_ff @(posedge clk) begin
		sing_v[0] <= (det == '0);
		den_v[0]  <= dmag;
		for (int k = 0; k < 9; k++) begin
			neg_v[0][k]  <= (adj[k][smi_pkg::AdjWidth-1] != det[DW-1]) && (adj[k] != '0);
			num_v[0][k]  <= NW'(adj[k][smi_pkg::AdjWidth-1] ? -adj[k] : adj[k])
				<< smi_pkg::ScaleBits;
			rem_v[0][k]  <= '0;
			quo_v[0][k]  <= '0;
		end
	end

	// One extra step yields the rounding bit as the quotient LSB.
	for (genvar g = 0; g < NSTG; g++) begin : g_div
		smi_div_stage u_stg (
			.clk(clk), .arst_n(arst_n), .vld_in(vld_v[g]), .sing_in(sing_v[g]),
			.neg_in(neg_v[g]), .den_in(den_v[g]), .num_in(num_v[g]),
			.rem_in(rem_v[g]), .quo_in(quo_v[g]),
			.vld_out(vld_v[g+1]), .sing_out(sing_v[g+1]), .neg_out(neg_v[g+1]),
			.den_out(den_v[g+1]), .num_out(num_v[g+1]), .rem_out(rem_v[g+1]),
			.quo_out(quo_v[g+1])
		);
	end

	// Rounding stage.
	logic [QW-1:0] mag_s1 [9];
	logic [8:0] neg_s1;
	logic sing_s1, vld_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= vld_v[NSTG];
			done   <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sing_s1 <= sing_v[NSTG];
		neg_s1  <= neg_v[NSTG];
		for (int k = 0; k < 9; k++) begin
			mag_s1[k] <= (quo_v[NSTG][k] >> 1) + QW'(quo_v[NSTG][k][0]);
		end
	end

	// Saturation and sign.
	logic [31:0] res [9];
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			if (sing_s1) begin
				res[k] = '0;
			end else if (neg_s1[k]) begin
				res[k] = (mag_s1[k] > QW'(33'h80000000)) ? 32'h80000000 : -mag_s1[k][31:0];
			end else begin
				res[k] = (mag_s1[k] > QW'(33'h7FFFFFFF)) ? 32'h7FFFFFFF : mag_s1[k][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		singular <= sing_s1;
		r00 <= res[0]; r01 <= res[1]; r02 <= res[2];
		r10 <= res[3]; r11 <= res[4]; r12 <= res[5];
		r20 <= res[6]; r21 <= res[7]; r22 <= res[8];
	end

	`include "small_matrix_inverse_macros.svh"
	`SMI_ASSERT_NEXT(a_done, clk, arst_n, vld_s1, done)
	`SMI_ASSERT_IMPL(a_busy, clk, arst_n, start, !busy)
	`SMI_ASSERT_NEXT(a_sing_zero, clk, arst_n, vld_s1 && sing_s1, singular && r00 == '0)
endmodule
